// ----- rtl/positional_list_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, operation and status codes, word types and control structs.
// ----------------------------------------------------------------------------
package ple_pkg;

  // List size (2 .. 63)
  localparam int CAPACITY = 32;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 6;
  localparam int ST_W   = 2;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PREPEND = 3'd0,
    OP_APPEND  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences accept, execute and result hand-off; owns out_valid.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ple_pkg::cmd_t cmd
);

  ple_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  // result register is free this cycle or is being taken
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ple_pkg::S_EXEC;
      end
      ple_pkg::S_EXEC: begin
        if (slot_free) state_nxt = ple_pkg::S_IDLE;
      end
      default: state_nxt = ple_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      ple_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ple_pkg::S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/ple_cells.sv -----
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Row of entry cells with parallel shift, entry count and result register.
// ----------------------------------------------------------------------------
module ple_cells (
  input  logic                clk,
  input  logic                rst_n,
  input  ple_pkg::cmd_t       cmd,
  input  ple_pkg::in_word_t   in_word,
  output ple_pkg::out_word_t  out_word
);

  // latched request
  logic [ple_pkg::OP_W-1:0]         op_r;
  logic signed [ple_pkg::VAL_W-1:0] val_r;
  logic [ple_pkg::POS_W-1:0]        pos_r;

  logic [ple_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic signed [ple_pkg::VAL_W-1:0] cells_r   [ple_pkg::CAPACITY];
  logic signed [ple_pkg::VAL_W-1:0] cells_nxt [ple_pkg::CAPACITY];
  ple_pkg::out_word_t               out_r, out_nxt;

  logic [ple_pkg::CMP_W-1:0]        pos_x, cnt_x, eff_pos;
  logic                             full, empty, ins, del;
  logic [ple_pkg::ST_W-1:0]         st;
  logic signed [ple_pkg::VAL_W-1:0] rd;

  assign pos_x = ple_pkg::CMP_W'(pos_r);
  assign cnt_x = ple_pkg::CMP_W'(count_r);
  assign full  = (count_r == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty = (count_r == '0);

  // operation decode and checks
  always_comb begin
    st      = ple_pkg::ST_OK;
    rd      = '0;
    ins     = 1'b0;
    del     = 1'b0;
    eff_pos = pos_x;
    case (op_r)
      ple_pkg::OP_PREPEND: begin
        eff_pos = '0;
        if (full) st = ple_pkg::ST_FULL;
        else ins = 1'b1;
      end
      ple_pkg::OP_APPEND: begin
        eff_pos = cnt_x;
        if (full) st = ple_pkg::ST_FULL;
        else ins = 1'b1;
      end
      ple_pkg::OP_INSERT: begin
        if (full) st = ple_pkg::ST_FULL;
        else if (pos_x > cnt_x) st = ple_pkg::ST_RANGE;
        else ins = 1'b1;
      end
      ple_pkg::OP_DELETE: begin
        if (empty) st = ple_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x) st = ple_pkg::ST_RANGE;
        else del = 1'b1;
      end
      ple_pkg::OP_READ: begin
        if (empty) st = ple_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x) st = ple_pkg::ST_RANGE;
        else rd = cells_r[pos_r[ple_pkg::IDX_W-1:0]];
      end
      default: ;
    endcase
  end

  // new count
  always_comb begin
    count_nxt = count_r;
    if (ins) count_nxt = count_r + 1'b1;
    else if (del) count_nxt = count_r - 1'b1;
  end

  // per-cell shift: insert moves cells above the position up, delete down
  always_comb begin
    int prv;
    int nxt;
    for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
      prv = (i == 0) ? 0 : i - 1;
      nxt = (i == ple_pkg::CAPACITY - 1) ? i : i + 1;
      cells_nxt[i] = cells_r[i];
      if (ins && ple_pkg::CMP_W'(i) == eff_pos) cells_nxt[i] = val_r;
      else if (ins && ple_pkg::CMP_W'(i) > eff_pos) cells_nxt[i] = cells_r[prv];
      else if (del && ple_pkg::CMP_W'(i) >= eff_pos) cells_nxt[i] = cells_r[nxt];
    end
  end

  // result word
  always_comb begin
    out_nxt.read_value = rd;
    out_nxt.status     = st;
    out_nxt.length     = ple_pkg::LEN_W'(count_nxt);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_word.operation;
      val_r <= in_word.value;
      pos_r <= in_word.position;
    end
    if (cmd.exec) begin
      cells_r <= cells_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_word = out_r;

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// A request word is latched when accepted, then executed into the result
// register; a new word is taken only after that. Execute waits while an
// earlier result has not been taken. The execute step shifts the whole cell
// row in parallel.
// Reset (rst_n, synchronous, active low) empties the list at once; cell
// contents are left as they were and no clearing pass runs.
// ----------------------------------------------------------------------------
// Positional list engine top level
// Ordered list of signed values with prepend, append, insert, delete and read.
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ple_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ple_pkg::out_word_t out_word
);

  ple_pkg::cmd_t cmd;

  // controller
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath
  ple_cells u_cells (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // one word in flight at a time
  `PLE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken while busy")

  // length never exceeds the list size
  `PLE_ASSERT_NOW(a_len_bound, out_valid, out_word.length <= ple_pkg::CAPACITY, "length over capacity")

  // failed requests return a zero value
  `PLE_ASSERT_NOW(a_fail_zero, out_valid && out_word.status != ple_pkg::ST_OK, out_word.read_value == '0, "nonzero value on failed request")

endmodule

// ----- sim/tb_positional_list_engine_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Sends request words through the valid/ready input channel: first a short
// table of directed requests, then random requests that run in growth,
// drain and mixed spells. A local list model predicts each result word that
// the table does not give. Both channels idle at random, except for one long stretch with no idling.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PCT       = 31;
  localparam int RANDOM_WORDS   = 600;
  localparam int SPELL_WORDS    = 60;
  localparam int STEADY_FIRST   = 200;
  localparam int STEADY_LAST    = 320;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  // Codes the block leaves unused
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [ple_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [ple_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [ple_pkg::VAL_W-1:0] VAL_ONES = 32'hffff_ffff;
  localparam logic [ple_pkg::POS_W-1:0] POS_TOP = '1;

  typedef enum int {
    TREND_GROW,
    TREND_DRAIN,
    TREND_MIXED
  } trend_t;

  typedef struct {
    logic [ple_pkg::OP_W-1:0]  op;
    logic [ple_pkg::VAL_W-1:0] val;
    logic [ple_pkg::POS_W-1:0] pos;
    bit                        typed;
    logic [ple_pkg::VAL_W-1:0] want_val;
    ple_pkg::status_t          want_st;
    int                        want_len;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ple_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ple_pkg::out_word_t out_word;

  // List model state
  logic [ple_pkg::VAL_W-1:0] list_cells [ple_pkg::CAPACITY];
  int                        list_len = 0;

  ple_pkg::out_word_t awaited_words [$];
  stim_row_t          directed_rows [$];
  bit                 steady_flow = 1'b0;
  int                 mismatch_count = 0;
  int                 words_checked = 0;
  int                 peak_len = 0;
  int                 status_seen [4] = '{0, 0, 0, 0};
  int                 quiet_cycles = 0;

  positional_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one request to the list model and return the result word
  function automatic ple_pkg::out_word_t apply_to_list(ple_pkg::in_word_t w);
    ple_pkg::out_word_t r;
    int                 pos;
    r = '0;
    r.status = ple_pkg::ST_OK;
    pos = int'(w.position);
    case (w.operation)
      ple_pkg::OP_PREPEND, ple_pkg::OP_APPEND, ple_pkg::OP_INSERT: begin
        if (w.operation == ple_pkg::OP_PREPEND) pos = 0;
        else if (w.operation == ple_pkg::OP_APPEND) pos = list_len;
        // full check comes ahead of the position check
        if (list_len >= ple_pkg::CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else if (pos > list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = w.value;
          list_len++;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      ple_pkg::OP_READ: begin
        if (list_len == 0) r.status = ple_pkg::ST_EMPTY;
        else if (pos >= list_len) r.status = ple_pkg::ST_RANGE;
        else r.read_value = list_cells[pos];
      end
      default: ;
    endcase
    r.length = ple_pkg::LEN_W'(list_len);
    return r;
  endfunction

  function automatic bit take_gap();
    return !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Present one word, hold it until taken, then log what must come back
  task automatic send_request(ple_pkg::in_word_t w, bit typed,
                              ple_pkg::out_word_t typed_result);
    ple_pkg::out_word_t predicted;
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_list(w);
    awaited_words.push_back(typed ? typed_result : predicted);
  endtask

  task automatic add_row(logic [ple_pkg::OP_W-1:0] op, logic [ple_pkg::VAL_W-1:0] val,
                         logic [ple_pkg::POS_W-1:0] pos, bit typed,
                         logic [ple_pkg::VAL_W-1:0] want_val,
                         ple_pkg::status_t want_st, int want_len);
    stim_row_t row;
    row.op       = op;
    row.val      = val;
    row.pos      = pos;
    row.typed    = typed;
    row.want_val = want_val;
    row.want_st  = want_st;
    row.want_len = want_len;
    directed_rows.push_back(row);
  endtask

  function automatic logic [ple_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ple_pkg::OP_W-1:0] OP_OP_W_UNUSED();
    return ple_pkg::OP_W'($urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST)));
  endfunction

  function automatic ple_pkg::in_word_t random_request(trend_t trend);
    ple_pkg::in_word_t w;
    int                write_pct;
    int                delete_pct;
    int                roll;
    int                top;
    case (trend)
      TREND_GROW:  begin write_pct = 65; delete_pct = 15; end
      TREND_DRAIN: begin write_pct = 15; delete_pct = 65; end
      default:     begin write_pct = 35; delete_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < write_pct) begin
      case ($urandom_range(0, 2))
        0: w.operation = ple_pkg::OP_PREPEND;
        1: w.operation = ple_pkg::OP_APPEND;
        default: w.operation = ple_pkg::OP_INSERT;
      endcase
    end else if (roll < write_pct + delete_pct) begin
      w.operation = ple_pkg::OP_DELETE;
    end else if (roll < 97) begin
      w.operation = ple_pkg::OP_READ;
    end else begin
      w.operation = OP_OP_W_UNUSED();
    end
    w.value = random_value();
    // mostly legal positions, now and then anything the field holds
    top = (w.operation == ple_pkg::OP_INSERT || list_len == 0) ? list_len : list_len - 1;
    if ($urandom_range(0, 99) < 80) w.position = ple_pkg::POS_W'($urandom_range(0, top));
    else w.position = ple_pkg::POS_W'($urandom_range(0, 63));
    return w;
  endfunction

  // Stimulus
  initial begin
    ple_pkg::in_word_t  w;
    ple_pkg::out_word_t typed_result;
    trend_t             trend;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // op, value, position, typed?, read value, status, length
    add_row(ple_pkg::OP_READ,    '0,       '0,      1, '0,      ple_pkg::ST_EMPTY, 0);
    add_row(ple_pkg::OP_DELETE,  '0,       '0,      1, '0,      ple_pkg::ST_EMPTY, 0);
    add_row(ple_pkg::OP_INSERT,  32'd1,    6'd1,    1, '0,      ple_pkg::ST_RANGE, 0);
    add_row(ple_pkg::OP_INSERT,  VAL_MAX,  '0,      1, '0,      ple_pkg::ST_OK,    1);
    add_row(ple_pkg::OP_DELETE,  '0,       6'd1,    1, '0,      ple_pkg::ST_RANGE, 1);
    add_row(ple_pkg::OP_DELETE,  '0,       POS_TOP, 1, '0,      ple_pkg::ST_RANGE, 1);
    add_row(ple_pkg::OP_READ,    '0,       '0,      1, VAL_MAX, ple_pkg::ST_OK,    1);
    add_row(ple_pkg::OP_DELETE,  '0,       '0,      1, '0,      ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_PREPEND, VAL_MIN,  POS_TOP, 1, '0,      ple_pkg::ST_OK,    1);
    add_row(ple_pkg::OP_APPEND,  VAL_ONES, POS_TOP, 1, '0,      ple_pkg::ST_OK,    2);
    add_row(ple_pkg::OP_INSERT,  32'h5555_5555, 6'd1, 0, '0,    ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_INSERT,  32'haaaa_aaaa, 6'd3, 0, '0,    ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_READ,    '0,       POS_TOP, 1, '0,      ple_pkg::ST_RANGE, 4);
    add_row(ple_pkg::OP_READ,    '0,       6'd4,    1, '0,      ple_pkg::ST_RANGE, 4);
    add_row(ple_pkg::OP_READ,    '0,       6'd1,    0, '0,      ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_READ,    '0,       6'd3,    0, '0,      ple_pkg::ST_OK,    0);
    add_row(OP_UNUSED_FIRST,     VAL_ONES, POS_TOP, 1, '0,      ple_pkg::ST_OK,    4);
    add_row(OP_UNUSED_MID,       VAL_ONES, POS_TOP, 1, '0,      ple_pkg::ST_OK,    4);
    add_row(OP_UNUSED_LAST,      VAL_ONES, POS_TOP, 1, '0,      ple_pkg::ST_OK,    4);
    add_row(ple_pkg::OP_DELETE,  '0,       '0,      0, '0,      ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_DELETE,  '0,       6'd2,    0, '0,      ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_READ,    '0,       '0,      0, '0,      ple_pkg::ST_OK,    0);
    add_row(ple_pkg::OP_PREPEND, '0,       '0,      0, '0,      ple_pkg::ST_OK,    0);

    foreach (directed_rows[i]) begin
      w.operation = directed_rows[i].op;
      w.value     = directed_rows[i].val;
      w.position  = directed_rows[i].pos;
      typed_result.read_value = directed_rows[i].want_val;
      typed_result.status     = directed_rows[i].want_st;
      typed_result.length     = ple_pkg::LEN_W'(directed_rows[i].want_len);
      send_request(w, directed_rows[i].typed, typed_result);
    end

    // Random spells; the first one is a growth spell
    trend = TREND_GROW;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n > 0 && n % SPELL_WORDS == 0) trend = trend_t'($urandom_range(0, 2));
      steady_flow = (n >= STEADY_FIRST && n < STEADY_LAST);
      send_request(random_request(trend), 1'b0, '0);
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d result words checked, list length peaked at %0d of %0d",
             words_checked, peak_len, ple_pkg::CAPACITY);
    $display("statuses seen: ok %0d, range %0d, full %0d, empty %0d",
             status_seen[ple_pkg::ST_OK], status_seen[ple_pkg::ST_RANGE],
             status_seen[ple_pkg::ST_FULL], status_seen[ple_pkg::ST_EMPTY]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side stalls
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    ple_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        mismatch_count++;
      end else begin
        want = awaited_words.pop_front();
        words_checked++;
        status_seen[out_word.status]++;
        if (int'(out_word.length) > peak_len) peak_len = int'(out_word.length);
        if (out_word.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value,
                 out_word.read_value);
          mismatch_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatch_count++;
        end
        if (out_word.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_word.length);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no word moving", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
